FILE: sv/aeau_pkg.sv
package aeau_pkg;

    // field widths fixed by the item formats
    localparam int MODE_W  = 2;
    localparam int ARR_W   = 8;
    localparam int DIM_W   = 4;
    localparam int CNT_W   = 5;
    localparam int VALUE_W = 32;

    // mode codes of an input beat
    localparam logic [MODE_W-1:0] MODE_HEADER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BOUNDS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INDEX  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [ARR_W-1:0]          array_number;
        logic [DIM_W-1:0]          dimension;
        logic [CNT_W-1:0]          dimension_count;
        logic signed [VALUE_W-1:0] first_value;
        logic signed [VALUE_W-1:0] second_value;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] element_address;
        logic [ARR_W-1:0]          result_array;
    } out_item_t;

    // what an offered input beat asks for, after range checks
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_HEADER,
        KIND_BOUNDS,
        KIND_INDEX
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_SCALE,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic wr_hdr;
        logic wr_bnd;
        logic start;
        logic load_ops;
        logic mac;
        logic scale;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  last;
        logic  out_free;
    } sts_t;

endpackage

FILE: sv/aeau_ram.sv
module aeau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/aeau_ctrl.sv
module aeau_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  aeau_pkg::sts_t  sts,
    output aeau_pkg::cmd_t  cmd
);

    aeau_pkg::state_t state_reg;
    aeau_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aeau_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            aeau_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (sts.kind)
                        aeau_pkg::KIND_HEADER: cmd.wr_hdr = 1'b1;
                        aeau_pkg::KIND_BOUNDS: cmd.wr_bnd = 1'b1;
                        aeau_pkg::KIND_INDEX: begin
                            cmd.start  = 1'b1;
                            state_next = aeau_pkg::ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            aeau_pkg::ST_READ: begin
                cmd.load_ops = 1'b1;
                state_next   = aeau_pkg::ST_MAC;
            end
            aeau_pkg::ST_MAC: begin
                cmd.mac    = 1'b1;
                state_next = sts.last ? aeau_pkg::ST_SCALE : aeau_pkg::ST_IDLE;
            end
            aeau_pkg::ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = aeau_pkg::ST_EMIT;
            end
            aeau_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = aeau_pkg::ST_IDLE;
                end
            end
            default: state_next = aeau_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: sv/aeau_dp.sv
module aeau_dp #(
    parameter int NUM_ARRAYS = 256,
    parameter int MAX_DIMS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  aeau_pkg::in_item_t   s_data,
    input  aeau_pkg::cmd_t       cmd,
    output aeau_pkg::sts_t       sts,
    output logic                 m_valid,
    input  logic                 m_ready,
    output aeau_pkg::out_item_t  m_data
);

    // only array numbers below both the parameter and the 8-bit field exist
    localparam int ADEPTH = (NUM_ARRAYS < 256) ? NUM_ARRAYS : 256;
    localparam int AW     = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
    localparam int DW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int BDEPTH = (2 ** AW) * (2 ** DW);
    localparam int VW     = aeau_pkg::VALUE_W;
    localparam int CW     = aeau_pkg::CNT_W;

    typedef struct packed {
        logic [CW-1:0] count;
        logic [VW-1:0] size;
        logic [VW-1:0] base;
    } hdr_t;

    typedef struct packed {
        logic [VW-1:0] upper;
        logic [VW-1:0] lower;
    } bnd_t;

    hdr_t hdr_wdata;
    hdr_t hdr_rdata;
    bnd_t bnd_wdata;
    bnd_t bnd_rdata;

    logic [AW-1:0]    arr_idx;
    logic [DW-1:0]    dim_idx;
    logic [DW-1:0]    rd_dim;
    logic             arr_ok;
    logic             dim_ok;
    logic [CW-1:0]    hdr_count;
    aeau_pkg::kind_t  beat_kind;

    aeau_pkg::in_item_t  item_reg;
    logic [CW-1:0]       cnt_reg;
    logic [VW-1:0]       acc_reg;
    logic [VW-1:0]       extent_reg;
    logic [VW-1:0]       diff_reg;
    logic                last_reg;
    logic [VW-1:0]       prod_reg;
    logic                m_valid_reg;
    aeau_pkg::out_item_t m_data_reg;
    logic [VW-1:0]       acc_next;
    logic [VW-1:0]       sum_next;

    // decode of the offered beat
    assign arr_idx = s_data.array_number[AW-1:0];
    assign dim_idx = DW'(s_data.dimension);
    assign arr_ok  = 17'(s_data.array_number) < 17'(NUM_ARRAYS);
    assign dim_ok  = 5'(s_data.dimension) < 5'(MAX_DIMS);

    always_comb begin
        beat_kind = aeau_pkg::KIND_NONE;
        if (arr_ok) begin
            case (s_data.mode)
                aeau_pkg::MODE_HEADER: beat_kind = aeau_pkg::KIND_HEADER;
                aeau_pkg::MODE_BOUNDS:
                    beat_kind = dim_ok ? aeau_pkg::KIND_BOUNDS : aeau_pkg::KIND_NONE;
                aeau_pkg::MODE_INDEX:  beat_kind = aeau_pkg::KIND_INDEX;
                default:               beat_kind = aeau_pkg::KIND_NONE;
            endcase
        end
    end

    // header count clamped to one through MAX_DIMS
    always_comb begin
        hdr_count = s_data.dimension_count;
        if (s_data.dimension_count == '0) begin
            hdr_count = CW'(1);
        end else if ({1'b0, s_data.dimension_count} > 6'(MAX_DIMS)) begin
            hdr_count = CW'(MAX_DIMS);
        end
    end

    assign hdr_wdata = '{count: hdr_count,
                         size:  unsigned'(s_data.second_value),
                         base:  unsigned'(s_data.first_value)};
    assign bnd_wdata = '{upper: unsigned'(s_data.second_value),
                         lower: unsigned'(s_data.first_value)};

    // bound row for the current index, held at the last dimension
    assign rd_dim = ({1'b0, cnt_reg} >= 6'(MAX_DIMS)) ? DW'(MAX_DIMS - 1) : DW'(cnt_reg);

    aeau_ram #(
        .WIDTH ($bits(hdr_t)),
        .DEPTH (ADEPTH)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (cmd.wr_hdr),
        .waddr (arr_idx),
        .wdata (hdr_wdata),
        .re    (cmd.start),
        .raddr (arr_idx),
        .rdata (hdr_rdata)
    );

    aeau_ram #(
        .WIDTH ($bits(bnd_t)),
        .DEPTH (BDEPTH)
    ) u_bnd_ram (
        .aclk  (aclk),
        .we    (cmd.wr_bnd),
        .waddr ({arr_idx, dim_idx}),
        .wdata (bnd_wdata),
        .re    (cmd.start),
        .raddr ({arr_idx, rd_dim}),
        .rdata (bnd_rdata)
    );

    // horner step and final address
    assign acc_next = acc_reg * extent_reg + diff_reg;
    assign sum_next = hdr_rdata.base + prod_reg;

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            item_reg <= s_data;
        end
        if (cmd.load_ops) begin
            extent_reg <= bnd_rdata.upper - bnd_rdata.lower + VW'(1);
            diff_reg   <= unsigned'(item_reg.first_value) - bnd_rdata.lower;
            last_reg   <= ({1'b0, cnt_reg} + 6'd1) >= {1'b0, hdr_rdata.count};
        end
        if (cmd.scale) begin
            prod_reg <= hdr_rdata.size * acc_reg;
        end
        if (cmd.emit) begin
            m_data_reg.element_address <= signed'(sum_next);
            m_data_reg.result_array    <= item_reg.array_number;
        end
    end

    // accumulator and dimension counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.wr_hdr || cmd.scale) begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.mac) begin
            acc_reg <= acc_next;
            if (!last_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    // output beat holding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts     = '{kind: beat_kind, last: last_reg, out_free: !m_valid_reg || m_ready};
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: sv/array_element_address_unit_core.sv
// channel   ports                          payload
// input     s_valid s_ready s_data         aeau_pkg::in_item_t
// result    m_valid m_ready m_data         aeau_pkg::out_item_t
//
// header and bound loads are taken directly from idle; an index beat that is
// not the last of a query passes the table read and the multiply-accumulate,
// the last one also the scale multiply and, once the result register is
// free, the base add; the registered table read and the two chained 32x32
// multiplies set these steps. reset (aresetn, synchronous, active low) clears the
// controller, accumulator, dimension counter and result valid; descriptor
// tables are not cleared. loads are taken while a result beat waits; a new
// result waits in the final step until the result register is free.
module array_element_address_unit_core #(
    parameter int NUM_ARRAYS = 256,
    parameter int MAX_DIMS   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  aeau_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output aeau_pkg::out_item_t m_data
);

    aeau_pkg::cmd_t cmd;
    aeau_pkg::sts_t sts;

    aeau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    aeau_dp #(
        .NUM_ARRAYS (NUM_ARRAYS),
        .MAX_DIMS   (MAX_DIMS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a result beat appears only from the final step of a query
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.emit))
        else $error("result valid rose without an emit step");

    // table writes and query starts only on accepted input beats
    a_write_on_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_hdr || cmd.wr_bnd || cmd.start) |-> (s_valid && s_ready))
        else $error("table access without an accepted beat");

    // no new beat is taken while a query item is in flight
    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start || cmd.scale) |=> !s_ready)
        else $error("input ready while an index beat is in flight");

endmodule

FILE: verif/testbench.sv
module testbench;

    localparam int MODE_W  = aeau_pkg::MODE_W;
    localparam int ARR_W   = aeau_pkg::ARR_W;
    localparam int DIM_W   = aeau_pkg::DIM_W;
    localparam int CNT_W   = aeau_pkg::CNT_W;
    localparam int VALUE_W = aeau_pkg::VALUE_W;

    localparam int N_ARR        = 256;
    localparam int N_DIM        = 16;
    localparam int RANDOM_BEATS = 1500;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_MAX   = 10;
    // mode code that the block ignores
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // one input beat with the address it is predicted to produce
    typedef struct packed {
        aeau_pkg::in_item_t  beat;
        logic                has_addr;
        aeau_pkg::out_item_t addr;
        logic                drain;
    } pending_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    aeau_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    aeau_pkg::out_item_t m_data;

    // descriptor tables and horner state of the address predictor
    logic [VALUE_W-1:0] base_mem   [N_ARR];
    logic [VALUE_W-1:0] esize_mem  [N_ARR];
    logic [CNT_W-1:0]   dcount_mem [N_ARR];
    logic [VALUE_W-1:0] lower_mem  [N_ARR*N_DIM];
    logic [VALUE_W-1:0] upper_mem  [N_ARR*N_DIM];
    logic [VALUE_W-1:0] offset_acc = '0;
    logic [CNT_W-1:0]   dim_index  = '0;

    // which descriptor entries the stimulus has written so far
    bit hdr_seen [N_ARR];
    bit bnd_seen [N_ARR*N_DIM];
    bit in_pool  [N_ARR];
    int pool_q[$];
    int query_arr;
    int beats_made;
    bit drain_next;

    pending_t            beat_q[$];
    pending_t            offered;
    aeau_pkg::out_item_t addr_expected[$];
    aeau_pkg::out_item_t addr_head;

    int released_count = 0;
    int seen_count     = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int tx_gap  = 0;
    int tx_calm = 0;
    int rx_hold = 0;
    int rx_calm = 0;

    array_element_address_unit_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // idle length: mostly none or short, a few long, now and then a calm stretch
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // updates the descriptor state for one beat; returns 1 when an address comes out
    function automatic bit predict_address(input aeau_pkg::in_item_t beat,
                                           output aeau_pkg::out_item_t addr);
        logic [VALUE_W-1:0] v1, lo, hi, extent;
        logic [CNT_W-1:0]   cnt, d;
        int                 arr, slot;
        bit                 done;
        v1   = beat.first_value;
        arr  = int'(beat.array_number);
        addr = '0;
        done = 1'b0;
        case (beat.mode)
            aeau_pkg::MODE_HEADER: begin
                cnt = beat.dimension_count;
                if (cnt == 0) cnt = CNT_W'(1);
                else if (cnt > N_DIM) cnt = CNT_W'(N_DIM);
                base_mem[arr]   = beat.first_value;
                esize_mem[arr]  = beat.second_value;
                dcount_mem[arr] = cnt;
                offset_acc      = '0;
                dim_index       = '0;
            end
            aeau_pkg::MODE_BOUNDS: begin
                slot            = arr * N_DIM + beat.dimension;
                lower_mem[slot] = beat.first_value;
                upper_mem[slot] = beat.second_value;
            end
            aeau_pkg::MODE_INDEX: begin
                cnt = dcount_mem[arr];
                if (cnt == 0) cnt = CNT_W'(1);
                d = (dim_index >= N_DIM) ? CNT_W'(N_DIM - 1) : dim_index;
                slot       = arr * N_DIM + d;
                lo         = lower_mem[slot];
                hi         = upper_mem[slot];
                extent     = hi - lo + 1;
                offset_acc = offset_acc * extent + (v1 - lo);
                if (dim_index + 1 >= cnt) begin
                    addr.element_address = base_mem[arr] + esize_mem[arr] * offset_acc;
                    addr.result_array    = beat.array_number;
                    offset_acc = '0;
                    dim_index  = '0;
                    done       = 1'b1;
                end else begin
                    dim_index = dim_index + CNT_W'(1);
                end
            end
            default: ;
        endcase
        return done;
    endfunction

    // queue one beat together with its predicted address
    task automatic send(input logic [MODE_W-1:0] mode, input int arr, input int dim,
                        input int cnt, input logic [VALUE_W-1:0] v1,
                        input logic [VALUE_W-1:0] v2);
        pending_t entry;
        entry.beat.mode            = mode;
        entry.beat.array_number    = ARR_W'(arr);
        entry.beat.dimension       = DIM_W'(dim);
        entry.beat.dimension_count = CNT_W'(cnt);
        entry.beat.first_value     = v1;
        entry.beat.second_value    = v2;
        entry.has_addr = predict_address(entry.beat, entry.addr);
        entry.drain    = drain_next;
        drain_next     = 1'b0;
        beat_q.push_back(entry);
        if (mode == aeau_pkg::MODE_HEADER) hdr_seen[entry.beat.array_number] = 1'b1;
        if (mode == aeau_pkg::MODE_BOUNDS)
            bnd_seen[entry.beat.array_number * N_DIM + entry.beat.dimension] = 1'b1;
        if (mode != MODE_SPARE) beats_made++;
    endtask

    task automatic send_bounds(input int arr, input int dim);
        logic [VALUE_W-1:0] lo, hi;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            lo = $urandom_range(0, 20) - 10;
            hi = lo + $urandom_range(1, 12) - 1;
        end else if (r < 90) begin
            lo = $urandom;
            hi = lo + $urandom_range(0, 300);
        end else begin
            lo = $urandom;
            hi = $urandom;
        end
        send(aeau_pkg::MODE_BOUNDS, arr, dim, $urandom, lo, hi);
    endtask

    // header plus the bounds of every dimension it declares
    task automatic define_array(input int arr);
        int                 r, cnt;
        logic [VALUE_W-1:0] base, esize;
        r = $urandom_range(0, 99);
        if (r < 75) cnt = $urandom_range(1, 4);
        else if (r < 90) cnt = $urandom_range(5, 16);
        else if (r < 95) cnt = 0;
        else cnt = $urandom_range(17, 31);
        base  = ($urandom_range(0, 99) < 50) ? $urandom_range(0, 4095) << 12 : $urandom;
        esize = ($urandom_range(0, 99) < 70) ? 1 << $urandom_range(0, 4) : $urandom;
        send(aeau_pkg::MODE_HEADER, arr, $urandom, cnt, base, esize);
        for (int d = 0; d < dcount_mem[arr]; d++) send_bounds(arr, d);
        if (!in_pool[arr]) begin
            in_pool[arr] = 1'b1;
            pool_q.push_back(arr);
        end
    endtask

    function automatic bit array_ready(input int arr);
        if (!hdr_seen[arr]) return 1'b0;
        for (int d = 0; d < dcount_mem[arr]; d++)
            if (!bnd_seen[arr * N_DIM + d]) return 1'b0;
        return 1'b1;
    endfunction

    // an index beat may only touch entries that were written
    function automatic bit index_ok(input int arr);
        return hdr_seen[arr] && bnd_seen[arr * N_DIM + dim_index];
    endfunction

    task automatic send_index(input int arr);
        logic [VALUE_W-1:0] lo, hi, extent, v;
        int                 slot;
        slot   = arr * N_DIM + dim_index;
        lo     = lower_mem[slot];
        hi     = upper_mem[slot];
        extent = hi - lo + 1;
        if ($urandom_range(0, 99) < 85 && extent != 0 && extent <= 1024)
            v = lo + $urandom_range(0, extent - 1);
        else
            v = $urandom;
        send(aeau_pkg::MODE_INDEX, arr, $urandom, $urandom, v, $urandom);
    endtask

    // stimulus, then reset, then wait for the last address and report
    initial begin
        int r, a, tries;
        // extremes: one dimension spanning the whole range, count 0 stored as 1
        send(aeau_pkg::MODE_HEADER, 0, 0, 0, 32'h7fff_ffff, 32'hffff_ffff);
        send(aeau_pkg::MODE_BOUNDS, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
        send(aeau_pkg::MODE_INDEX, 0, 0, 0, 32'h7fff_ffff, 32'h0000_0000);
        send(aeau_pkg::MODE_INDEX, 0, 15, 31, 32'h8000_0000, 32'hffff_ffff);
        // unused mode is ignored
        send(MODE_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom);
        // count above the limit stored as the limit, last dimension slot
        send(aeau_pkg::MODE_HEADER, 255, 15, 31, 32'h8000_0000, 32'h0000_0001);
        send(aeau_pkg::MODE_BOUNDS, 255, 15, 0, 32'h0000_0000, 32'hffff_ffff);
        // plain two dimensional query
        send(aeau_pkg::MODE_HEADER, 1, 0, 2, 32'h0000_1000, 32'h0000_0004);
        send(aeau_pkg::MODE_BOUNDS, 1, 0, 0, 32'hffff_ffff, 32'h0000_0002);
        send(aeau_pkg::MODE_BOUNDS, 1, 1, 0, 32'h0000_0000, 32'h0000_0009);
        send(aeau_pkg::MODE_INDEX, 1, 0, 0, 32'h0000_0000, 32'h0000_0000);
        send(aeau_pkg::MODE_INDEX, 1, 0, 0, 32'h0000_0003, 32'h0000_0000);
        // header in the middle of a query abandons it
        send(aeau_pkg::MODE_INDEX, 1, 0, 0, 32'h0000_0001, 32'h0000_0000);
        send(aeau_pkg::MODE_HEADER, 2, 0, 1, 32'h0000_0000, 32'h0000_0008);
        send(aeau_pkg::MODE_BOUNDS, 2, 0, 0, 32'h0000_0005, 32'h0000_000a);
        send(aeau_pkg::MODE_INDEX, 2, 0, 0, 32'h0000_0007, 32'h0000_0000);
        // mixed arrays: counter already past the second array's count
        send(aeau_pkg::MODE_BOUNDS, 0, 1, 0, 32'h0000_0003, 32'h0000_0003);
        send(aeau_pkg::MODE_INDEX, 1, 0, 0, 32'h0000_0002, 32'h0000_0000);
        send(aeau_pkg::MODE_INDEX, 0, 0, 0, 32'h0000_0004, 32'h0000_0000);
        // exactly the maximum count
        send(aeau_pkg::MODE_HEADER, 3, 0, 16, 32'h0001_0000, 32'h0000_0010);

        // random part: mostly complete queries, some loads and noise
        drain_next = 1'b1;
        while (beats_made < RANDOM_BEATS + 20) begin
            if ($urandom_range(0, 199) == 0) drain_next = 1'b1;
            r = $urandom_range(0, 99);
            if (dim_index != 0) begin
                if (r < 90) begin
                    if (index_ok(query_arr)) send_index(query_arr);
                    else define_array(query_arr);
                end else if (r < 93) begin
                    send(aeau_pkg::MODE_HEADER, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
                end else if (r < 96) begin
                    tries = 0;
                    a     = pool_q[$urandom_range(0, pool_q.size() - 1)];
                    while (!index_ok(a) && tries < 8) begin
                        a = pool_q[$urandom_range(0, pool_q.size() - 1)];
                        tries++;
                    end
                    if (index_ok(a)) send_index(a);
                end else if (r < 98) begin
                    send_bounds($urandom_range(0, N_ARR - 1), $urandom_range(0, N_DIM - 1));
                end else begin
                    send(MODE_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom);
                end
            end else begin
                if (r < 12 || pool_q.size() == 0) begin
                    define_array($urandom_range(0, N_ARR - 1));
                end else if (r < 85) begin
                    a = pool_q[$urandom_range(0, pool_q.size() - 1)];
                    if (array_ready(a)) begin
                        query_arr = a;
                        send_index(a);
                    end else begin
                        define_array(a);
                    end
                end else if (r < 93) begin
                    send_bounds($urandom_range(0, N_ARR - 1), $urandom_range(0, N_DIM - 1));
                end else if (r < 96) begin
                    send(aeau_pkg::MODE_HEADER, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
                end else begin
                    send(MODE_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom);
                end
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        do @(negedge aclk);
        while (beat_q.size() != 0 || s_valid || addr_expected.size() != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (addr_expected.size() != 0) begin
            $display("%0d expected addresses never arrived", addr_expected.size());
            mismatch_count += addr_expected.size();
        end
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // input driver: offers queued beats, waits for the result side when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (offered.has_addr) begin
                    addr_expected.push_back(offered.addr);
                    released_count++;
                end
                tx_gap = pick_gap(tx_calm);
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (beat_q.size() != 0 &&
                             !(beat_q[0].drain && released_count != seen_count)) begin
                    offered = beat_q.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= offered.beat;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each address beat with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                seen_count <= seen_count + 1;
                if (addr_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result beat: address %h array %0d",
                                 m_data.element_address, m_data.result_array);
                end else begin
                    addr_head = addr_expected.pop_front();
                    if (m_data.element_address !== addr_head.element_address ||
                        m_data.result_array !== addr_head.result_array) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("mismatch: expected address %h array %0d, got %h array %0d",
                                     addr_head.element_address, addr_head.result_array,
                                     m_data.element_address, m_data.result_array);
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else begin
                rx_hold = pick_gap(rx_calm);
                m_ready <= (rx_hold == 0);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("no progress for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
